/* rtl/chm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the chained hash map engine.
// Depends on nothing; used by the top level.
package chm_pkg;

   localparam int HASH_W     = 64;
   localparam int HASH_SHIFT = 5;
   localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

   localparam int FILL_W    = 4;
   localparam int LEN_W     = 4;
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = HASH_W / MOD_BITS;

   typedef logic [0:0] req_kind_type;
   typedef logic [1:0] status_type;

   localparam req_kind_type REQ_INSERT = 1'b0;
   localparam req_kind_type REQ_FIND   = 1'b1;

   localparam status_type STATUS_INSERTED  = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_FOUND     = 2'd2;
   localparam status_type STATUS_NOT_FOUND = 2'd3;

endpackage

/* rtl/chained_hash_map_engine_unit.sv */
`timescale 1ns / 1ps
// Hash table engine with fixed-depth buckets: insert and find transactions.
// Depends on chm_pkg and chm_ram (bucket fill counts and bucket entries).
//
// One transaction is handled at a time. The key is hashed one byte per cycle,
// the bucket index is then reduced four bits per cycle (skipped when
// NUM_BUCKETS is a power of two), the fill count is read from its RAM, and a
// find compares the stored entries one at a time through the single entry RAM
// read port, oldest entry first. The result is then registered into the output
// register once the previous response has been taken; that register holds it
// while the next transaction is accepted. After reset the fill count RAM is
// cleared one bucket per cycle, and no transaction is accepted during
// that pass.
module chained_hash_map_engine_unit #(
   parameter int NUM_BUCKETS  = 64,
   parameter int BUCKET_DEPTH = 8,
   parameter int KEY_BYTES    = 8,
   parameter int VALUE_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // key_bytes [63:0], key_len [67:64], value_word [99:68], zero [103:100]
   input  logic [103:0]           req_tdata,
   // req_type [0]
   input  chm_pkg::req_kind_type  req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // found_value [31:0]
   output logic [31:0]            rsp_tdata,
   // status [1:0]
   output chm_pkg::status_type    rsp_tuser
);
   import chm_pkg::*;

   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int SW    = $clog2(SLOTS);
   localparam int KW    = 8 * KEY_BYTES;
   localparam int EW    = VALUE_BITS + LEN_W + KW;
   localparam int MCW   = $clog2(MOD_STEPS);
   localparam bit POW2  = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   localparam logic [BW:0]      N_C     = (BW + 1)'(NUM_BUCKETS);
   localparam logic [BW-1:0]    LAST_B  = BW'(NUM_BUCKETS - 1);
   localparam logic [SW-1:0]    DEPTH_S = SW'(BUCKET_DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUCKET_DEPTH);
   localparam logic [LEN_W-1:0] KEYB_L  = LEN_W'(KEY_BYTES);
   localparam logic [MCW-1:0]   MOD_LAST = MCW'(MOD_STEPS - 1);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HASH   = 4'd2;
   localparam logic [3:0] S_MOD    = 4'd3;
   localparam logic [3:0] S_FILLRD = 4'd4;
   localparam logic [3:0] S_FILLWT = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_CMP    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [BW-1:0]      clr_ff, clr_in;
   req_kind_type       kind_ff, kind_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [KW-1:0]      mask_ff, mask_in;
   logic [KW-1:0]      hkey_ff, hkey_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [MCW-1:0]     mcnt_ff, mcnt_in;
   logic [BW-1:0]      rem_ff, rem_in;
   logic [BW-1:0]      bkt_ff, bkt_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   status_type         res_status_ff, res_status_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;

   logic               fill_wr_en, fill_rd_en;
   logic [BW-1:0]      fill_wr_addr;
   logic [FILL_W-1:0]  fill_wr_data, fill_rd_data, fill_sat;
   logic               ent_wr_en, ent_rd_en;
   logic [SW-1:0]      ent_wr_addr, ent_rd_addr, slot_base;
   logic [EW-1:0]      ent_wr_data, ent_rd_data;
   logic [KW-1:0]      ent_key;
   logic [VALUE_BITS-1:0] ent_value;

   logic [LEN_W-1:0]   req_len;
   logic [KW-1:0]      req_mask;
   logic [7:0]         cur_byte;
   logic [BW-1:0]      rem_next;

   assign req_len = (req_tdata[67:64] > KEYB_L) ? KEYB_L : req_tdata[67:64];

   always_comb begin
      for (int j = 0; j < KEY_BYTES; j++) begin
         req_mask[8*j +: 8] = (LEN_W'(j) < req_len) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      logic [BW:0]   t;
      logic [BW-1:0] r;
      r = rem_ff;
      t = '0;
      for (int k = 0; k < MOD_BITS; k++) begin
         t = {r, hash_ff[HASH_W-1-k]};
         if (t >= N_C) begin
            t = t - N_C;
         end
         r = t[BW-1:0];
      end
      rem_next = r;
   end

   assign cur_byte  = hkey_ff[7:0];
   assign fill_sat  = (fill_rd_data > DEPTH_F) ? DEPTH_F : fill_rd_data;
   assign slot_base = SW'(bkt_ff) * DEPTH_S;
   assign ent_key   = ent_rd_data[KW-1:0];
   assign ent_value = ent_rd_data[EW-1 -: VALUE_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      key_in        = key_ff;
      mask_in       = mask_ff;
      hkey_in       = hkey_ff;
      value_in      = value_ff;
      hash_in       = hash_ff;
      cnt_in        = cnt_ff;
      mcnt_in       = mcnt_ff;
      rem_in        = rem_ff;
      bkt_in        = bkt_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      fill_wr_en    = 1'b0;
      fill_wr_addr  = bkt_ff;
      fill_wr_data  = fill_sat + FILL_W'(1);
      fill_rd_en    = 1'b0;
      ent_wr_en     = 1'b0;
      ent_wr_addr   = slot_base + SW'(fill_sat);
      ent_wr_data   = {value_ff, len_ff, key_ff};
      ent_rd_en     = 1'b0;
      ent_rd_addr   = slot_base + SW'(idx_ff);

      case (state_ff)
         S_CLEAR: begin
            fill_wr_en   = 1'b1;
            fill_wr_addr = clr_ff;
            fill_wr_data = '0;
            clr_in       = clr_ff + BW'(1);
            if (clr_ff == LAST_B) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               len_in   = req_len;
               mask_in  = req_mask;
               key_in   = KW'(req_tdata[63:0]) & req_mask;
               hkey_in  = KW'(req_tdata[63:0]) & req_mask;
               value_in = VALUE_BITS'(req_tdata[99:68]);
               hash_in  = HASH_SEED;
               cnt_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (cnt_ff == len_ff || cur_byte == 8'd0) begin
               mcnt_in = '0;
               rem_in  = '0;
               if (POW2) begin
                  bkt_in   = hash_ff[BW-1:0];
                  state_in = S_FILLRD;
               end else begin
                  state_in = S_MOD;
               end
            end else begin
               hash_in = (hash_ff << HASH_SHIFT) + hash_ff + HASH_W'(cur_byte);
               hkey_in = hkey_ff >> 8;
               cnt_in  = cnt_ff + LEN_W'(1);
            end
         end
         S_MOD: begin
            rem_in  = rem_next;
            hash_in = hash_ff << MOD_BITS;
            mcnt_in = mcnt_ff + MCW'(1);
            if (mcnt_ff == MOD_LAST) begin
               bkt_in   = rem_next;
               state_in = S_FILLRD;
            end
         end
         S_FILLRD: begin
            fill_rd_en = 1'b1;
            state_in   = S_FILLWT;
         end
         S_FILLWT: begin
            res_value_in = '0;
            idx_in       = '0;
            fill_in      = fill_sat;
            if (kind_ff == REQ_INSERT) begin
               state_in = S_DONE;
               if (fill_sat >= DEPTH_F) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  res_status_in = STATUS_INSERTED;
                  fill_wr_en    = 1'b1;
                  ent_wr_en     = 1'b1;
               end
            end else if (fill_sat == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ent_rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if ((ent_key & mask_ff) == key_ff) begin
               res_status_in = STATUS_FOUND;
               res_value_in  = 32'(ent_value);
               state_in      = S_DONE;
            end else if (idx_ff + FILL_W'(1) == fill_ff) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      len_ff        <= len_in;
      key_ff        <= key_in;
      mask_ff       <= mask_in;
      hkey_ff       <= hkey_in;
      value_ff      <= value_in;
      hash_ff       <= hash_in;
      cnt_ff        <= cnt_in;
      mcnt_ff       <= mcnt_in;
      rem_ff        <= rem_in;
      bkt_ff        <= bkt_in;
      fill_ff       <= fill_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   chm_ram #(
      .WIDTH(FILL_W),
      .DEPTH(NUM_BUCKETS)
   ) u_fill_ram (
      .clock  (clock),
      .wr_en  (fill_wr_en),
      .wr_addr(fill_wr_addr),
      .wr_data(fill_wr_data),
      .rd_en  (fill_rd_en),
      .rd_addr(bkt_ff),
      .rd_data(fill_rd_data)
   );

   chm_ram #(
      .WIDTH(EW),
      .DEPTH(SLOTS)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ent_wr_en),
      .wr_addr(ent_wr_addr),
      .wr_data(ent_wr_data),
      .rd_en  (ent_rd_en),
      .rd_addr(ent_rd_addr),
      .rd_data(ent_rd_data)
   );

`ifndef SYNTH
   a_value_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_FOUND |-> rsp_tdata == 32'd0)
      else $error("Result value is nonzero on a status other than found.");

   a_no_accept_while_clearing: assert property (@(posedge clock)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("A transaction was offered ready during the clearing pass.");

   a_scan_below_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> idx_ff < fill_ff && fill_ff <= DEPTH_F)
      else $error("Bucket scan went past the fill count.");

   a_fill_update_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_wr_en && state_ff != S_CLEAR |-> ent_wr_en && fill_wr_data <= DEPTH_F
         && fill_wr_data != '0)
      else $error("Fill count update without an entry write or out of range.");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_HASH)
      else $error("Accepted transaction did not start hashing.");
`endif

endmodule

/* rtl/chm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for chained_hash_map_engine_unit: directed and random insert and
// find transactions with random stalls on both stream channels, checked against a
// table model kept in the bench. Depends on chm_pkg and the engine RTL.
module testbench;
   import chm_pkg::*;

   localparam int NUM_BUCKETS  = 64;
   localparam int BUCKET_DEPTH = 8;
   localparam int KEY_BYTES    = 8;
   localparam int VALUE_BITS   = 32;
   localparam int SLOT_COUNT   = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG     = 4000;

   typedef struct {
      req_kind_type kind;
      logic [63:0]  key;
      logic [3:0]   len;
      logic [31:0]  value;
   } map_req_type;

   typedef struct {
      status_type  status;
      logic [31:0] value;
   } map_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   req_kind_type req_tuser = REQ_INSERT;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   status_type   rsp_tuser;

   map_req_type pending_reqs[$];
   map_rsp_type expected_rsps[$];
   map_req_type cur_req;
   logic        req_taken = 1'b0;

   logic [3:0]  bucket_fill[NUM_BUCKETS];
   logic [63:0] slot_key[SLOT_COUNT];
   logic [31:0] slot_value[SLOT_COUNT];

   int total_items = 0;
   int req_accepted = 0;
   int rsp_accepted = 0;
   int error_count = 0;
   int insert_count = 0;
   int full_count = 0;
   int find_count = 0;
   int hit_count = 0;
   int idle_cycles = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int seg_left = 0;
   int stall_pct = 0;

   chained_hash_map_engine_unit #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .BUCKET_DEPTH(BUCKET_DEPTH),
      .KEY_BYTES   (KEY_BYTES),
      .VALUE_BITS  (VALUE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] byte_mask(int len);
      if (len <= 0) return 64'd0;
      if (len >= KEY_BYTES) return {64{1'b1}};
      return {64{1'b1}} >> (64 - 8 * len);
   endfunction

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   // Keys drawn from a tiny alphabet collide often and carry zero bytes.
   function automatic logic [63:0] rand_key();
      logic [63:0] k;
      logic [7:0]  alphabet[4];
      alphabet = '{8'h00, 8'h01, 8'h61, 8'h62};
      k = rand_word64();
      if ($urandom_range(0, 2) == 0) begin
         for (int i = 0; i < 8; i++) k[8*i +: 8] = alphabet[$urandom_range(0, 3)];
      end
      return k;
   endfunction

   function automatic logic [3:0] rand_len();
      if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   function automatic void add_req(req_kind_type kind, logic [63:0] key, logic [3:0] len,
                                   logic [31:0] value);
      map_req_type r;
      r.kind  = kind;
      r.key   = key;
      r.len   = len;
      r.value = value;
      pending_reqs.push_back(r);
      total_items++;
   endfunction

   function automatic map_rsp_type table_apply(map_req_type r);
      map_rsp_type res;
      int          len;
      int          bkt;
      int          fill;
      int          slot;
      logic [63:0] km;
      logic [63:0] key;
      logic [63:0] hash;
      len  = (r.len > KEY_BYTES) ? KEY_BYTES : int'(r.len);
      km   = byte_mask(len);
      key  = r.key & km;
      hash = HASH_SEED;
      for (int i = 0; i < len; i++) begin
         if (key[8*i +: 8] == 8'd0) break;
         hash = (hash << HASH_SHIFT) + hash + 64'(key[8*i +: 8]);
      end
      bkt  = int'(hash % 64'(NUM_BUCKETS));
      fill = int'(bucket_fill[bkt]);
      if (fill > BUCKET_DEPTH) fill = BUCKET_DEPTH;
      res.status = STATUS_INSERTED;
      res.value  = 32'd0;
      if (r.kind == REQ_INSERT) begin
         insert_count++;
         if (fill >= BUCKET_DEPTH) begin
            res.status = STATUS_FULL;
            full_count++;
         end else begin
            slot = bkt * BUCKET_DEPTH + fill;
            slot_key[slot]   = key;
            slot_value[slot] = r.value;
            bucket_fill[bkt] = 4'(fill + 1);
         end
      end else begin
         find_count++;
         res.status = STATUS_NOT_FOUND;
         for (int i = 0; i < fill; i++) begin
            slot = bkt * BUCKET_DEPTH + i;
            if ((slot_key[slot] & km) == key) begin
               res.status = STATUS_FOUND;
               res.value  = slot_value[slot];
               hit_count++;
               break;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      map_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_accepted++;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with no pending expectation: status %0d value %h",
                      rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_tuser !== exp_rsp.status) begin
                  $error("status mismatch: expected %0d, actual %0d", exp_rsp.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== exp_rsp.value) begin
                  $error("found_value mismatch: expected %h, actual %h", exp_rsp.value,
                         rsp_tdata);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(table_apply(cur_req));
            req_accepted++;
            req_taken <= 1'b1;
         end else begin
            req_taken <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      map_req_type r;
      logic        quiet;
      if (!reset) begin
         quiet = pending_reqs.size() < QUIET_TAIL;
         if (seg_left == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 8;
               default: stall_pct = 25;
            endcase
            seg_left = $urandom_range(100, 400);
         end else begin
            seg_left--;
         end
         if (quiet) stall_pct = 0;

         if (!req_tvalid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               cur_req    <= r;
               req_tdata  <= {4'd0, r.value, r.len, r.key};
               req_tuser  <= r.kind;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 99) < stall_pct) req_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end

         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) rsp_gap = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] pool_key[$];
      logic [3:0]  pool_len[$];
      logic [63:0] key;
      logic [3:0]  len;
      int          idx;
      int          pick;

      for (int b = 0; b < NUM_BUCKETS; b++) bucket_fill[b] = 4'd0;

      add_req(REQ_INSERT, {64{1'b1}}, 4'd8, 32'hffff_ffff);
      add_req(REQ_FIND, {64{1'b1}}, 4'd8, 32'd0);
      add_req(REQ_INSERT, 64'hdead_beef_cafe_f00d, 4'd0, 32'h1234_5678);
      add_req(REQ_FIND, 64'h0123_4567_89ab_cdef, 4'd0, 32'hffff_ffff);
      add_req(REQ_INSERT, 64'h0102_0304_0506_0708, 4'd15, 32'd0);
      add_req(REQ_FIND, 64'h0102_0304_0506_0708, 4'd9, 32'd0);
      add_req(REQ_INSERT, 64'hffff_ffff_ff42_0041, 4'd3, 32'h0000_0a0a);
      add_req(REQ_FIND, 64'h0000_0000_0042_0041, 4'd3, 32'd0);
      add_req(REQ_FIND, 64'h0000_0000_0000_0041, 4'd3, 32'd0);
      add_req(REQ_FIND, 64'h0000_0000_dead_beef, 4'd4, 32'd0);
      for (int i = 0; i < BUCKET_DEPTH + 1; i++) begin
         add_req(REQ_INSERT, 64'h7777_0000_0000_5a5a, 4'd2, 32'h100 + 32'(i));
      end
      add_req(REQ_FIND, 64'h0000_0000_0000_5a5a, 4'd2, 32'd0);
      add_req(REQ_FIND, 64'h0000_0000_0000_005a, 4'd1, 32'd0);
      add_req(REQ_INSERT, 64'd0, 4'd8, 32'd0);
      add_req(REQ_FIND, 64'd0, 4'd8, 32'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 || pool_key.size() == 0) begin
            if (pool_key.size() > 0 && $urandom_range(0, 3) == 0) begin
               idx = $urandom_range(0, pool_key.size() - 1);
               key = pool_key[idx] | (rand_word64() & ~byte_mask(pool_len[idx]));
               len = pool_len[idx];
            end else begin
               key = rand_key();
               len = rand_len();
               pool_key.push_back(key & byte_mask(len));
               pool_len.push_back(len);
            end
            add_req(REQ_INSERT, key, len, $urandom);
         end else if (pick < 90) begin
            idx = $urandom_range(0, pool_key.size() - 1);
            len = pool_len[idx];
            if (len > 0 && $urandom_range(0, 3) == 0) len = 4'($urandom_range(0, len));
            key = (pool_key[idx] & byte_mask(len)) | (rand_word64() & ~byte_mask(len));
            add_req(REQ_FIND, key, len, $urandom);
         end else begin
            add_req(REQ_FIND, rand_key(), rand_len(), $urandom);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_accepted == total_items);
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions: %0d inserts (%0d into full buckets), %0d finds (%0d hits).",
               req_accepted, insert_count, full_count, find_count, hit_count);
      $display("Received %0d responses with %0d mismatches.", rsp_accepted, error_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
